### sv/ocr_pkg.sv
// shared types, codes and tables for the orbit camera rotation block
`default_nettype none
package ocr_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_CINIT,
    S_CORD,
    S_ROUND,
    S_MUL,
    S_DONE
  } ocr_state_t;

  // input kinds
  localparam logic [1:0] MODE_ADD_PITCH = 2'd0;
  localparam logic [1:0] MODE_ADD_YAW   = 2'd1;
  localparam logic [1:0] MODE_SET_PITCH = 2'd2;
  localparam logic [1:0] MODE_SET_YAW   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_PITCH_LIMIT  = 3'd0;
  localparam logic [2:0] REG_HOME_X       = 3'd1;
  localparam logic [2:0] REG_HOME_Y       = 3'd2;
  localparam logic [2:0] REG_HOME_Z       = 3'd3;
  localparam logic [2:0] REG_PITCH_ENABLE = 3'd4;
  localparam logic [2:0] REG_YAW_ENABLE   = 3'd5;
  localparam logic [2:0] REG_UP_ENABLE    = 3'd6;

  localparam logic [22:0] PITCH_LIMIT_RST = 23'd5898174;

  // degrees-to-turn division: (deg*8192 + 22) / 45, biased positive by 45*2^39
  localparam int DIV_W = 48;
  localparam int DIV_STEPS = 12;
  localparam logic [DIV_W-1:0] DIV_BIAS = 48'd24739011624960;
  localparam logic [6:0] DIV_DEN = 7'd45;

  // cordic start value in Q4.30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // arctangent per step in 32-bit turns
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // saturate a 36-bit value to 32 bits
  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/orbit_camera_rotation.sv
// orbit camera pitch/yaw tracking with cordic trig and rotated home position
//
//  channel | direction | handshake               | payload
//  in_     | slave     | in_tvalid / in_tready   | tdata angle, tuser mode
//  out_    | master    | out_tvalid / out_tready | tdata angles, position, up terms
//  cfg_    | slave     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// each of the two angles of an item goes through the degrees-to-turn divider and the
// shared cordic unit one step per cycle, then one shared multiplier runs eight products.
// reset (rst_n low, synchronous) clears angles, up terms and registers to defaults.
// in_tready is high only while idle; a finished result waits in the output register
// and the next item may be taken while it waits.
`default_nettype none
module orbit_camera_rotation #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_ITERS = 18
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // angle[31:0]
  input  wire logic [1:0]   in_tuser,   // mode[1:0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pitch_now[23:0] yaw_now[55:24] pos_x[87:56] pos_y[119:88] pos_z[151:120]
  // up_x_out[169:152] up_z_out[187:170], zero above
  output logic [191:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  import ocr_pkg::*;

  localparam int BW   = FRAC_BITS + 2;
  localparam int SH   = 30 - FRAC_BITS;
  localparam int AW   = 36;
  localparam int PW   = AW + BW;
  localparam int ACCW = PW + 1;

  ocr_state_t state_r, state_nxt;

  // configuration
  logic [22:0]        pitch_limit_r;
  logic signed [31:0] home_x_r, home_y_r, home_z_r;
  logic               pitch_en_r, yaw_en_r, up_en_r;

  // angle state
  logic signed [23:0] pitch_r;
  logic signed [31:0] yaw_r;
  logic signed [17:0] up_x_r, up_z_r;
  logic               do_up_r, sel_r;

  // datapath registers
  logic [4:0]              cnt_r;
  logic [DIV_W-1:0]        num_r;
  logic [5:0]              rem_r;
  logic [31:0]             quot_r;
  logic signed [33:0]      x_r, y_r;
  logic signed [31:0]      a_r;
  logic [1:0]              q_r;
  logic signed [BW-1:0]    cp_r, sp_r, cy_r, sy_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACCW-1:0]  acc_r;
  logic signed [AW-1:0]    z1_r, y1_r, px_r, pz_r;
  logic                    out_valid_r;
  logic [191:0]            out_data_r;

  // angle update on input transfer
  logic signed [31:0] ang_w;
  logic signed [33:0] psum_w, ysum_w, lim_w;
  logic signed [23:0] pitch_new_w;
  logic signed [31:0] yaw_new_w;
  logic               is_yaw_w;

  always_comb begin
    ang_w    = $signed(in_tdata);
    lim_w    = $signed({11'b0, pitch_limit_r});
    is_yaw_w = (in_tuser == MODE_ADD_YAW) || (in_tuser == MODE_SET_YAW);
    if (in_tuser == MODE_ADD_PITCH) begin
      psum_w = 34'(pitch_r) + 34'(ang_w);
    end else begin
      psum_w = 34'(ang_w);
    end
    if (in_tuser == MODE_ADD_YAW) begin
      ysum_w = 34'(yaw_r) + 34'(ang_w);
    end else begin
      ysum_w = 34'(ang_w);
    end
    if (psum_w > lim_w) begin
      pitch_new_w = lim_w[23:0];
    end else if (psum_w < -lim_w) begin
      pitch_new_w = 24'(-lim_w);
    end else begin
      pitch_new_w = psum_w[23:0];
    end
    if (ysum_w > 34'sd2147483647) begin
      yaw_new_w = 32'sh7FFF_FFFF;
    end else if (ysum_w < -34'sd2147483648) begin
      yaw_new_w = 32'sh8000_0000;
    end else begin
      yaw_new_w = ysum_w[31:0];
    end
  end

  // divider: four quotient bits per cycle, remainder below 45
  logic [5:0] rem_w;
  logic [3:0] qbits_w;
  logic [6:0] trial_w;

  always_comb begin
    rem_w   = rem_r;
    qbits_w = '0;
    trial_w = '0;
    for (int j = 0; j < 4; j++) begin
      trial_w = {rem_w, num_r[DIV_W-1-j]};
      if (trial_w >= DIV_DEN) begin
        rem_w          = 6'(trial_w - DIV_DEN);
        qbits_w[3-j]   = 1'b1;
      end else begin
        rem_w          = trial_w[5:0];
      end
    end
  end

  // degrees of the angle being worked on
  logic signed [31:0] deg_w;
  logic [DIV_W-1:0]   num_init_w;
  logic [31:0]        zturn_w;

  always_comb begin
    deg_w      = sel_r ? yaw_r : 32'(pitch_r);
    num_init_w = DIV_W'($signed({{(DIV_W-32){deg_w[31]}}, deg_w}) <<< 13) + 48'd22 + DIV_BIAS;
    zturn_w    = quot_r + 32'h2000_0000;
  end

  // cordic step
  logic signed [33:0] dx_w, dy_w;
  logic signed [31:0] atan_w;

  always_comb begin
    dx_w   = y_r >>> cnt_r;
    dy_w   = x_r >>> cnt_r;
    atan_w = $signed(atan_turn(cnt_r));
  end

  // rounding to FRAC_BITS and to 16 bits, clamped, then quadrant fold
  logic signed [33:0] xa_w, ya_w, xs_w, ys_w, x16_w, y16_w;
  logic signed [BW-1:0] cc_w, ss_w, c_w, s_w;
  logic signed [17:0]   cc16_w, ss16_w, c16_w, s16_w;
  localparam logic signed [33:0] ONE_F  = 34'sd1 <<< FRAC_BITS;
  localparam logic signed [33:0] ONE_16 = 34'sd65536;

  always_comb begin
    xa_w  = x_r + (34'sd1 <<< (SH - 1));
    ya_w  = y_r + (34'sd1 <<< (SH - 1));
    xs_w  = xa_w >>> SH;
    ys_w  = ya_w >>> SH;
    x16_w = (x_r + 34'sd8192) >>> 14;
    y16_w = (y_r + 34'sd8192) >>> 14;
    if (xs_w > ONE_F) cc_w = BW'(ONE_F);
    else if (xs_w < -ONE_F) cc_w = BW'(-ONE_F);
    else cc_w = xs_w[BW-1:0];
    if (ys_w > ONE_F) ss_w = BW'(ONE_F);
    else if (ys_w < -ONE_F) ss_w = BW'(-ONE_F);
    else ss_w = ys_w[BW-1:0];
    if (x16_w > ONE_16) cc16_w = 18'(ONE_16);
    else if (x16_w < -ONE_16) cc16_w = 18'(-ONE_16);
    else cc16_w = x16_w[17:0];
    if (y16_w > ONE_16) ss16_w = 18'(ONE_16);
    else if (y16_w < -ONE_16) ss16_w = 18'(-ONE_16);
    else ss16_w = y16_w[17:0];
    unique case (q_r)
      2'd0: begin c_w = cc_w;  s_w = ss_w;  c16_w = cc16_w;  s16_w = ss16_w;  end
      2'd1: begin c_w = -ss_w; s_w = cc_w;  c16_w = -ss16_w; s16_w = cc16_w;  end
      2'd2: begin c_w = -cc_w; s_w = -ss_w; c16_w = -cc16_w; s16_w = -ss16_w; end
      default: begin c_w = ss_w; s_w = -cc_w; c16_w = ss16_w; s16_w = -cc16_w; end
    endcase
  end

  // multiplier operand select and accumulate
  logic signed [AW-1:0]   mop_a_w;
  logic signed [BW-1:0]   mop_b_w;
  logic [2:0]             k_w;
  logic                   neg_w;
  logic signed [ACCW-1:0] addend_w, sum_w, rnd_w;

  always_comb begin
    unique case (cnt_r[2:0])
      3'd0: begin mop_a_w = AW'(home_y_r); mop_b_w = sp_r; end
      3'd1: begin mop_a_w = AW'(home_z_r); mop_b_w = cp_r; end
      3'd2: begin mop_a_w = AW'(home_y_r); mop_b_w = cp_r; end
      3'd3: begin mop_a_w = AW'(home_z_r); mop_b_w = sp_r; end
      3'd4: begin mop_a_w = AW'(home_x_r); mop_b_w = cy_r; end
      3'd5: begin mop_a_w = z1_r;          mop_b_w = sy_r; end
      3'd6: begin mop_a_w = z1_r;          mop_b_w = cy_r; end
      default: begin mop_a_w = AW'(home_x_r); mop_b_w = sy_r; end
    endcase
    k_w      = 3'(cnt_r - 5'd1);
    neg_w    = (k_w == 3'd3) || (k_w == 3'd7);
    addend_w = neg_w ? -ACCW'(prod_r) : ACCW'(prod_r);
    sum_w    = acc_r + addend_w;
    rnd_w    = (sum_w + (ACCW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_DIV;
      S_DIV:   if (cnt_r == 5'(DIV_STEPS - 1)) state_nxt = S_CINIT;
      S_CINIT: state_nxt = S_CORD;
      S_CORD:  if (cnt_r == 5'(CORDIC_ITERS - 1)) state_nxt = S_ROUND;
      S_ROUND: state_nxt = sel_r ? S_MUL : S_LOAD;
      S_MUL:   if (cnt_r == 5'd8) state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_tready  = (state_r == S_IDLE);
    cfg_ready  = 1'b1;
    out_tvalid = out_valid_r;
    out_tdata  = out_data_r;
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pitch_r     <= '0;
      yaw_r       <= '0;
      up_x_r      <= '0;
      up_z_r      <= '0;
      do_up_r     <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_IDLE && in_tvalid) begin
        sel_r   <= 1'b0;
        do_up_r <= is_yaw_w && yaw_en_r && up_en_r;
        if (!is_yaw_w && pitch_en_r) pitch_r <= pitch_new_w;
        if (is_yaw_w && yaw_en_r) yaw_r <= yaw_new_w;
      end
      if (state_r == S_ROUND) begin
        sel_r <= 1'b1;
        if (sel_r && do_up_r) begin
          up_z_r <= c16_w;
          up_x_r <= s16_w;
        end
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_limit_r <= PITCH_LIMIT_RST;
      home_x_r      <= '0;
      home_y_r      <= '0;
      home_z_r      <= '0;
      pitch_en_r    <= 1'b1;
      yaw_en_r      <= 1'b1;
      up_en_r       <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PITCH_LIMIT:  pitch_limit_r <= cfg_data[22:0];
        REG_HOME_X:       home_x_r      <= $signed(cfg_data);
        REG_HOME_Y:       home_y_r      <= $signed(cfg_data);
        REG_HOME_Z:       home_z_r      <= $signed(cfg_data);
        REG_PITCH_ENABLE: pitch_en_r    <= cfg_data[0];
        REG_YAW_ENABLE:   yaw_en_r      <= cfg_data[0];
        REG_UP_ENABLE:    up_en_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // shared datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_LOAD: begin
        num_r <= num_init_w;
        rem_r <= '0;
        cnt_r <= '0;
      end
      S_DIV: begin
        num_r  <= num_r << 4;
        rem_r  <= rem_w;
        quot_r <= {quot_r[27:0], qbits_w};
        cnt_r  <= cnt_r + 5'd1;
      end
      S_CINIT: begin
        q_r   <= zturn_w[31:30];
        a_r   <= $signed({2'b00, zturn_w[29:0]}) - 32'sh2000_0000;
        x_r   <= CORDIC_GAIN;
        y_r   <= '0;
        cnt_r <= '0;
      end
      S_CORD: begin
        if (!a_r[31]) begin
          x_r <= x_r - dx_w;
          y_r <= y_r + dy_w;
          a_r <= a_r - atan_w;
        end else begin
          x_r <= x_r + dx_w;
          y_r <= y_r - dy_w;
          a_r <= a_r + atan_w;
        end
        cnt_r <= cnt_r + 5'd1;
      end
      S_ROUND: begin
        if (sel_r) begin
          cy_r <= c_w;
          sy_r <= s_w;
        end else begin
          cp_r <= c_w;
          sp_r <= s_w;
        end
        cnt_r <= '0;
      end
      S_MUL: begin
        prod_r <= mop_a_w * mop_b_w;
        if (cnt_r != 5'd0) begin
          if (!k_w[0]) begin
            acc_r <= addend_w;
          end else begin
            unique case (k_w[2:1])
              2'd0: z1_r <= rnd_w[AW-1:0];
              2'd1: y1_r <= rnd_w[AW-1:0];
              2'd2: px_r <= rnd_w[AW-1:0];
              default: pz_r <= rnd_w[AW-1:0];
            endcase
          end
        end
        cnt_r <= cnt_r + 5'd1;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_r <= {4'b0, up_z_r, up_x_r, sat32(pz_r), sat32(y1_r), sat32(px_r),
                         yaw_r, pitch_r};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
